@@ rtl/pklc_pkg.sv @@
// ----------------------------------------------------------------------------
// Per-key live count table package
// Shared widths, codes, state encoding and record layouts of the table.
// ----------------------------------------------------------------------------
package pklc_pkg;

   localparam int KEY_W          = 64;
   localparam int SLOT_IDX_W     = 14;
   localparam int LIVE_W         = 64;
   localparam int COUNT_W        = 63;
   localparam int HASH_W         = 60;
   localparam int HASH_SHIFT_LO  = 4;
   localparam int HASH_SHIFT_HI  = 20;
   localparam int SLOTS_DEFAULT  = 16384;

   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   localparam logic [1:0] OP_CREATE  = 2'd0;
   localparam logic [1:0] OP_DESTROY = 2'd1;
   localparam logic [1:0] OP_READ    = 2'd2;
   localparam logic [1:0] OP_NONE    = 2'd3;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_HASH,
      ST_PROBE,
      ST_UPDATE,
      ST_READ
   } state_type;

   typedef struct packed {
      logic [KEY_W-1:0]   key;
      logic [LIVE_W-1:0]  live;
      logic [COUNT_W-1:0] total;
      logic [COUNT_W-1:0] peak;
   } slot_entry_type;

   typedef struct packed {
      logic                  found;
      logic [SLOT_IDX_W-1:0] slot_index;
      logic                  occupied;
      logic [KEY_W-1:0]      key;
      logic [LIVE_W-1:0]     live;
      logic [COUNT_W-1:0]    total;
      logic [COUNT_W-1:0]    peak;
   } rsp_type;

   function automatic logic [HASH_W-1:0] key_hash(input logic [KEY_W-1:0] key);
      key_hash = HASH_W'(key >> HASH_SHIFT_LO) ^ HASH_W'(key >> HASH_SHIFT_HI);
   endfunction

endpackage

@@ rtl/pklc_hash.sv @@
// ----------------------------------------------------------------------------
// Per-key live count table: home slot unit
// Hashes a key and reduces the hash modulo the table size. A power-of-two
// table takes the low bits of the hash into a register; any other size folds
// the hash three times with a constant multiply and finishes with a reciprocal
// multiplication and a subtraction of the quotient times the table size.
// ----------------------------------------------------------------------------
module pklc_hash #(
   parameter int SLOTS = pklc_pkg::SLOTS_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [pklc_pkg::KEY_W-1:0] key,
   output logic                       done,
   output logic [$clog2(SLOTS)-1:0]   pos
);
   import pklc_pkg::*;

   localparam int IDX_W = $clog2(SLOTS);

   if ((SLOTS & (SLOTS - 1)) == 0) begin : g_pow2
      logic             done_ff;
      logic [IDX_W-1:0] pos_ff;

      always_ff @(posedge clock) begin
         if (reset) begin
            done_ff <= 1'b0;
         end else begin
            done_ff <= start;
         end
      end

      always_ff @(posedge clock) begin
         if (start) begin
            pos_ff <= IDX_W'(key_hash(key));
         end
      end

      assign done = done_ff;
      assign pos  = pos_ff;
   end else begin : g_mod
      localparam int FOLD_W      = HASH_W / 2;
      localparam int FOLDS       = 3;
      localparam int STEPS       = FOLDS + 2;
      localparam int STEP_W      = $clog2(STEPS);
      localparam int RED_W       = FOLD_W + 1;
      localparam int RECIP_W     = RED_W + 2;
      localparam int RECIP_SHIFT = RED_W + IDX_W;
      localparam int QUO_W       = RED_W + RECIP_W - RECIP_SHIFT;
      localparam logic [IDX_W-1:0]   MODULUS = IDX_W'(SLOTS);
      localparam logic [IDX_W-1:0]   FOLD_R  = IDX_W'((2 ** FOLD_W) % SLOTS);
      localparam logic [RECIP_W-1:0] RECIP   =
         RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(SLOTS) - 64'd1) / 64'(SLOTS));

      logic                     run_ff;
      logic                     done_ff;
      logic [STEP_W-1:0]        step_ff;
      logic [HASH_W-1:0]        val_ff;
      logic [QUO_W-1:0]         quo_ff;
      logic [IDX_W-1:0]         rem_ff;
      logic [FOLD_W+IDX_W-1:0]  fold_prod;
      logic [HASH_W-1:0]        fold_sum;
      logic [RED_W+RECIP_W-1:0] recip_prod;
      logic [QUO_W+IDX_W-1:0]   back_prod;
      logic [RED_W-1:0]         rem_wide;

      always_comb begin
         fold_prod  = val_ff[HASH_W-1:FOLD_W] * FOLD_R;
         fold_sum   = HASH_W'(fold_prod) + HASH_W'(val_ff[FOLD_W-1:0]);
         recip_prod = val_ff[RED_W-1:0] * RECIP;
         back_prod  = quo_ff * MODULUS;
         rem_wide   = val_ff[RED_W-1:0] - back_prod[RED_W-1:0];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            run_ff  <= 1'b0;
            done_ff <= 1'b0;
            step_ff <= '0;
         end else begin
            done_ff <= 1'b0;
            if (start) begin
               run_ff  <= 1'b1;
               step_ff <= '0;
            end else if (run_ff) begin
               step_ff <= step_ff + 1'b1;
               if (step_ff == STEP_W'(STEPS - 1)) begin
                  run_ff  <= 1'b0;
                  done_ff <= 1'b1;
               end
            end
         end
      end

      always_ff @(posedge clock) begin
         if (start) begin
            val_ff <= key_hash(key);
         end else if (run_ff && (step_ff < STEP_W'(FOLDS))) begin
            val_ff <= fold_sum;
         end
      end

      always_ff @(posedge clock) begin
         if (run_ff && (step_ff == STEP_W'(FOLDS))) begin
            quo_ff <= recip_prod[RED_W+RECIP_W-1:RECIP_SHIFT];
         end
         if (run_ff && (step_ff == STEP_W'(STEPS - 1))) begin
            rem_ff <= rem_wide[IDX_W-1:0];
         end
      end

      assign done = done_ff;
      assign pos  = rem_ff;
   end

endmodule

@@ rtl/pklc_store.sv @@
// ----------------------------------------------------------------------------
// Per-key live count table: slot memory
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module pklc_store #(
   parameter int SLOTS = pklc_pkg::SLOTS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            wr_en,
   input  logic [$clog2(SLOTS)-1:0]        wr_addr,
   input  pklc_pkg::slot_entry_type        wr_data,
   input  logic [$clog2(SLOTS)-1:0]        rd_addr,
   output pklc_pkg::slot_entry_type        rd_data
);
   import pklc_pkg::*;

   slot_entry_type mem [SLOTS];
   slot_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/per_key_live_count_hash_table_unit.sv @@
// ----------------------------------------------------------------------------
// Per-key live count hash table
// Open-addressing table with linear probing that keeps live, total and peak
// counts per 64-bit key, with create, destroy and read-by-slot items.
// ----------------------------------------------------------------------------
// After reset the block clears its slot memory, one slot per cycle, and
// holds busy high until the last slot is cleared. A create or destroy item
// first finds its home slot: with a power-of-two table the low bits of the
// key hash, with any other table size the result of a fold and reciprocal
// unit. The linear probe then reads the single slot memory once per cycle,
// up to a slot with the same key or an empty one, and updates that slot.
// A read item reads the named slot directly. An item with key zero, an
// unknown operation or a slot number beyond the table gets found low.
// Every item gives exactly one result, shown for one cycle with rsp_strobe
// high; the receiver must take it then, as the block never holds it.
// ----------------------------------------------------------------------------
module per_key_live_count_hash_table_unit #(
   parameter int SLOTS = pklc_pkg::SLOTS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [1:0]                           req_operation,
   input  logic [pklc_pkg::KEY_W-1:0]           req_class_key,
   input  logic [pklc_pkg::SLOT_IDX_W-1:0]      req_slot_number,
   output logic                                 rsp_strobe,
   output logic                                 rsp_found,
   output logic [pklc_pkg::SLOT_IDX_W-1:0]      rsp_slot_index,
   output logic                                 rsp_occupied,
   output logic [pklc_pkg::KEY_W-1:0]           rsp_key_out,
   output logic signed [pklc_pkg::LIVE_W-1:0]   rsp_live_count,
   output logic [pklc_pkg::COUNT_W-1:0]         rsp_total_count,
   output logic [pklc_pkg::COUNT_W-1:0]         rsp_peak_count
);
   import pklc_pkg::*;

   localparam int IDX_W = $clog2(SLOTS);
   localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(SLOTS - 1);

   state_type      state_ff, state_in;
   logic [1:0]     op_ff, op_in;
   logic [KEY_W-1:0] key_ff, key_in;
   logic [IDX_W-1:0] pos_ff, pos_in;
   logic [IDX_W-1:0] cnt_ff, cnt_in;
   logic [IDX_W-1:0] clr_ff, clr_in;
   slot_entry_type ent_ff, ent_in;
   rsp_type        rsp_ff, rsp_in;
   logic           rsp_strobe_ff, rsp_strobe_in;

   logic             accept;
   logic             req_oor;
   logic             req_keyed;
   logic             probe_hit;
   logic             probe_last;
   logic [IDX_W-1:0] pos_next;
   logic             hash_start;
   logic             hash_done;
   logic [IDX_W-1:0] hash_pos;
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   slot_entry_type   wr_data;
   logic [IDX_W-1:0] rd_addr;
   slot_entry_type   rd_data;
   slot_entry_type   new_ent;
   logic [LIVE_W-1:0] live_inc;

   function automatic rsp_type make_rsp(input logic [SLOT_IDX_W-1:0] idx,
                                        input slot_entry_type e);
      rsp_type r;
      r.found      = 1'b1;
      r.slot_index = idx;
      r.occupied   = (e.key != '0);
      r.key        = e.key;
      r.live       = e.live;
      r.total      = e.total;
      r.peak       = e.peak;
      return r;
   endfunction

   pklc_hash #(
      .SLOTS (SLOTS)
   ) u_hash (
      .clock (clock),
      .reset (reset),
      .start (hash_start),
      .key   (key_in),
      .done  (hash_done),
      .pos   (hash_pos)
   );

   pklc_store #(
      .SLOTS (SLOTS)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign accept     = start && (state_ff == ST_IDLE);
   assign req_oor    = 32'(req_slot_number) >= 32'(SLOTS);
   assign req_keyed  = (req_operation inside {OP_CREATE, OP_DESTROY}) &&
                       (req_class_key != '0);
   assign probe_hit  = (rd_data.key == key_ff) || (rd_data.key == '0);
   assign probe_last = (cnt_ff == LAST_SLOT);
   assign pos_next   = (pos_ff == LAST_SLOT) ? '0 : pos_ff + 1'b1;
   assign live_inc   = ent_ff.live + LIVE_W'(1);

   always_comb begin
      new_ent = ent_ff;
      if (op_ff == OP_CREATE) begin
         new_ent.live = live_inc;
         if (ent_ff.total != COUNT_MAX) begin
            new_ent.total = ent_ff.total + 1'b1;
         end
         if ($signed(live_inc) > $signed({1'b0, ent_ff.peak})) begin
            new_ent.peak = live_inc[COUNT_W-1:0];
         end
      end else begin
         new_ent.live = ent_ff.live - LIVE_W'(1);
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == LAST_SLOT) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               if (req_operation == OP_READ && !req_oor) begin
                  state_in = ST_READ;
               end else if (req_keyed) begin
                  state_in = ST_HASH;
               end
            end
         end
         ST_HASH: begin
            if (hash_done) begin
               state_in = ST_PROBE;
            end
         end
         ST_PROBE: begin
            if (probe_hit) begin
               state_in = ST_UPDATE;
            end else if (probe_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_UPDATE: state_in = ST_IDLE;
         ST_READ:   state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      op_in         = op_ff;
      key_in        = key_ff;
      pos_in        = pos_ff;
      cnt_in        = cnt_ff;
      clr_in        = clr_ff;
      ent_in        = ent_ff;
      rsp_in        = rsp_ff;
      rsp_strobe_in = 1'b0;
      rd_addr       = pos_ff;
      wr_en         = 1'b0;
      wr_addr       = pos_ff;
      wr_data       = new_ent;
      hash_start    = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = '0;
            clr_in  = clr_ff + 1'b1;
         end
         ST_IDLE: begin
            if (accept) begin
               op_in   = req_operation;
               key_in  = req_class_key;
               pos_in  = IDX_W'(req_slot_number);
               rd_addr = IDX_W'(req_slot_number);
               if (req_operation == OP_READ) begin
                  if (req_oor) begin
                     rsp_strobe_in     = 1'b1;
                     rsp_in            = '0;
                     rsp_in.slot_index = req_slot_number;
                  end
               end else if (req_keyed) begin
                  hash_start = 1'b1;
               end else begin
                  rsp_strobe_in = 1'b1;
                  rsp_in        = '0;
               end
            end
         end
         ST_HASH: begin
            if (hash_done) begin
               pos_in  = hash_pos;
               rd_addr = hash_pos;
               cnt_in  = '0;
            end
         end
         ST_PROBE: begin
            if (probe_hit) begin
               ent_in     = rd_data;
               ent_in.key = key_ff;
            end else if (probe_last) begin
               rsp_strobe_in = 1'b1;
               rsp_in        = '0;
            end else begin
               pos_in  = pos_next;
               rd_addr = pos_next;
               cnt_in  = cnt_ff + 1'b1;
            end
         end
         ST_UPDATE: begin
            wr_en         = 1'b1;
            wr_addr       = pos_ff;
            wr_data       = new_ent;
            rsp_strobe_in = 1'b1;
            rsp_in        = make_rsp(SLOT_IDX_W'(pos_ff), new_ent);
         end
         ST_READ: begin
            rsp_strobe_in = 1'b1;
            rsp_in        = make_rsp(SLOT_IDX_W'(pos_ff), rd_data);
         end
         default: begin
            rsp_strobe_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff  <= op_in;
      key_ff <= key_in;
      pos_ff <= pos_in;
      cnt_ff <= cnt_in;
      ent_ff <= ent_in;
      rsp_ff <= rsp_in;
   end

   assign busy            = (state_ff != ST_IDLE);
   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_found       = rsp_ff.found;
   assign rsp_slot_index  = rsp_ff.slot_index;
   assign rsp_occupied    = rsp_ff.occupied;
   assign rsp_key_out     = rsp_ff.key;
   assign rsp_live_count  = $signed(rsp_ff.live);
   assign rsp_total_count = rsp_ff.total;
   assign rsp_peak_count  = rsp_ff.peak;

endmodule
